### rtl/ccs_pkg.sv
package ccs_pkg;

    // default sizes
    localparam int MAX_TERMS_DEF  = 32;
    localparam int PRIME_BITS_DEF = 52;

    // fixed field widths
    localparam int BASE_W     = 32;
    localparam int EXP_W      = 32;
    localparam int CLEN_W     = 6;
    localparam int KW         = 63;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 63;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE     = 3'd0,
        CFG_EXPONENT = 3'd1,
        CFG_CHAIN    = 3'd2,
        CFG_SECOND   = 3'd3,
        CFG_HALF_K   = 3'd4,
        CFG_MIN_K    = 3'd5,
        CFG_MAX_K    = 3'd6
    } t_cfg_idx;

    // reset values of the registers
    localparam logic [BASE_W-1:0] RST_BASE     = 32'd2;
    localparam logic [EXP_W-1:0]  RST_EXPONENT = 32'd1;
    localparam logic [CLEN_W-1:0] RST_CHAIN    = 6'd2;
    localparam logic [KW-1:0]     RST_MIN_K    = 63'd1;
    localparam logic [KW-1:0]     RST_MAX_K    = 63'd1000000;

    // settings seen by the front part
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [EXP_W-1:0]  exponent;
        logic              second_kind;
    } t_front_cfg;

    // settings seen by the back part
    typedef struct packed {
        logic              base_two;
        logic              half_k;
        logic [CLEN_W-1:0] chain_length;
        logic [KW-1:0]     min_k;
        logic [KW-1:0]     max_k;
    } t_back_cfg;

endpackage

### rtl/ccs_front.sv
module ccs_front #(
    parameter int PRIME_BITS = ccs_pkg::PRIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ccs_pkg::t_front_cfg    i_cfg,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [PRIME_BITS-1:0]  i_prime,
    output logic                   o_push,
    input  logic                   i_full,
    output logic [PRIME_BITS-1:0]  o_p,
    output logic [PRIME_BITS-1:0]  o_k,
    output logic                   o_k_ok
);
    import ccs_pkg::*;

    localparam int PB = PRIME_BITS;
    localparam int NW = (PB > BASE_W) ? PB : BASE_W;
    localparam int SW = PB + 2;
    localparam int CW = $clog2(NW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_BMOD, S_EUC, S_EDIV, S_POW, S_MDBL, S_MADD, S_MDONE, S_PUSH
    } t_state;

    t_state               r_state;
    logic [PB-1:0]        r_p;
    logic [NW-1:0]        r_num;
    logic [PB-1:0]        r_rem;
    logic [CW-1:0]        r_cnt;
    logic [PB-1:0]        r_r0;
    logic [PB-1:0]        r_r1;
    logic signed [SW-1:0] r_t0;
    logic signed [SW-1:0] r_t1;
    logic signed [SW-1:0] r_tacc;
    logic [PB-1:0]        r_inv;
    logic [PB-1:0]        r_acc;
    logic [PB-1:0]        r_ma;
    logic [PB-1:0]        r_mb;
    logic [PB-1:0]        r_mr;
    logic [4:0]           r_bit;
    logic                 r_sq;
    logic                 r_k_ok;

    logic [PB-1:0]        div;
    logic [PB:0]          rem_sh;
    logic [PB:0]          rem_sub;
    logic                 ge;
    logic [PB-1:0]        rem_nx;
    logic signed [SW-1:0] tacc_nx;
    logic [PB-1:0]        am_y;
    logic [PB:0]          am_s;
    logic [PB:0]          am_r;
    logic [PB-1:0]        mr_nx;
    logic signed [SW-1:0] inv_sum;

    // one restoring division step, quotient folded into the cofactor
    always_comb begin
        div     = (r_state == S_BMOD) ? r_p : r_r1;
        rem_sh  = {r_rem, r_num[NW-1]};
        rem_sub = rem_sh - {1'b0, div};
        ge      = (rem_sh >= {1'b0, div});
        rem_nx  = ge ? rem_sub[PB-1:0] : rem_sh[PB-1:0];
        tacc_nx = (r_tacc <<< 1) + (ge ? r_t1 : SW'(0));
    end

    // modular add for the shift-add multiplier
    always_comb begin
        am_y  = (r_state == S_MDBL) ? r_mr : r_ma;
        am_s  = {1'b0, r_mr} + {1'b0, am_y};
        am_r  = (am_s >= {1'b0, r_p}) ? (am_s - {1'b0, r_p}) : am_s;
        mr_nx = am_r[PB-1:0];
    end

    assign inv_sum = r_t0 + $signed({2'b00, r_p});

    // sequencer: base mod p, inverse, then power
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_p <= i_prime;
                        if (i_prime < PB'(2)) begin
                            r_k_ok  <= 1'b0;
                            r_state <= S_PUSH;
                        end else begin
                            r_num   <= NW'(i_cfg.base) << (NW - BASE_W);
                            r_rem   <= '0;
                            r_cnt   <= CW'(BASE_W);
                            r_state <= S_BMOD;
                        end
                    end
                end
                S_BMOD: begin
                    r_rem <= rem_nx;
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_r0    <= r_p;
                        r_r1    <= rem_nx;
                        r_t0    <= '0;
                        r_t1    <= SW'(1);
                        r_state <= S_EUC;
                    end
                end
                S_EUC: begin
                    if (r_r1 == '0) begin
                        if (r_r0 == PB'(1)) begin
                            r_inv   <= (r_t0 < 0) ? inv_sum[PB-1:0] : r_t0[PB-1:0];
                            r_state <= S_POW;
                        end else begin
                            r_k_ok  <= 1'b0;
                            r_state <= S_PUSH;
                        end
                    end else begin
                        r_num   <= NW'(r_r0) << (NW - PB);
                        r_rem   <= '0;
                        r_tacc  <= '0;
                        r_cnt   <= CW'(PB);
                        r_state <= S_EDIV;
                    end
                end
                S_EDIV: begin
                    r_rem  <= rem_nx;
                    r_num  <= r_num << 1;
                    r_tacc <= tacc_nx;
                    r_cnt  <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_r0    <= r_r1;
                        r_r1    <= rem_nx;
                        r_t0    <= r_t1;
                        r_t1    <= r_t0 - tacc_nx;
                        r_state <= S_EUC;
                    end
                end
                S_POW: begin
                    r_bit   <= 5'd31;
                    r_sq    <= 1'b1;
                    r_ma    <= PB'(1);
                    r_mb    <= PB'(1);
                    r_mr    <= '0;
                    r_cnt   <= CW'(PB);
                    r_state <= S_MDBL;
                end
                S_MDBL: begin
                    r_mr <= mr_nx;
                    if (r_mb[PB-1]) begin
                        r_state <= S_MADD;
                    end else begin
                        r_mb    <= r_mb << 1;
                        r_cnt   <= r_cnt - CW'(1);
                        r_state <= (r_cnt == CW'(1)) ? S_MDONE : S_MDBL;
                    end
                end
                S_MADD: begin
                    r_mr    <= mr_nx;
                    r_mb    <= r_mb << 1;
                    r_cnt   <= r_cnt - CW'(1);
                    r_state <= (r_cnt == CW'(1)) ? S_MDONE : S_MDBL;
                end
                S_MDONE: begin
                    r_acc <= r_mr;
                    r_mr  <= '0;
                    r_cnt <= CW'(PB);
                    r_ma  <= r_mr;
                    if (r_sq && i_cfg.exponent[r_bit]) begin
                        r_sq    <= 1'b0;
                        r_mb    <= r_inv;
                        r_state <= S_MDBL;
                    end else if (r_bit == 5'd0) begin
                        r_k_ok  <= 1'b1;
                        r_state <= S_PUSH;
                    end else begin
                        r_bit   <= r_bit - 5'd1;
                        r_sq    <= 1'b1;
                        r_mb    <= r_mr;
                        r_state <= S_MDBL;
                    end
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_push  = (r_state == S_PUSH) && !i_full;
    assign o_p     = r_p;
    assign o_k     = i_cfg.second_kind ? (r_p - r_acc) : r_acc;
    assign o_k_ok  = r_k_ok;

endmodule

### rtl/ccs_queue.sv
module ccs_queue #(
    parameter int WIDTH = 2 * ccs_pkg::PRIME_BITS_DEF + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;

    // two-entry ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_data;
                r_wr        <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];

endmodule

### rtl/ccs_back.sv
module ccs_back #(
    parameter int PRIME_BITS = ccs_pkg::PRIME_BITS_DEF,
    parameter int MAX_TERMS  = ccs_pkg::MAX_TERMS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ccs_pkg::t_back_cfg            i_cfg,
    input  logic                          i_empty,
    input  logic [PRIME_BITS-1:0]         i_p,
    input  logic [PRIME_BITS-1:0]         i_k,
    input  logic                          i_k_ok,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [PRIME_BITS-1:0]         o_prime_out,
    output logic [ccs_pkg::KW-1:0]        o_k_value,
    output logic [ccs_pkg::CLEN_W-1:0]    o_term_index,
    output logic                          o_hit,
    output logic                          o_last
);
    import ccs_pkg::*;

    localparam int PB  = PRIME_BITS;
    localparam int TW  = $clog2(MAX_TERMS + 1);
    localparam int MCW = $clog2(KW + 1);

    typedef enum logic [2:0] {B_IDLE, B_TERM, B_MOD, B_PAR, B_EMIT} t_state;

    t_state         r_state;
    logic [PB-1:0]  r_p;
    logic [PB-1:0]  r_k;
    logic           r_ok;
    logic [TW-1:0]  r_t;
    logic [TW-1:0]  r_cnt;
    logic [63:0]    r_adj;
    logic [KW-1:0]  r_num;
    logic [PB-1:0]  r_rem;
    logic [MCW-1:0] r_mc;

    logic           r_out_valid;
    logic [PB-1:0]  r_out_p;
    logic [KW-1:0]  r_out_k;
    logic [CLEN_W-1:0] r_out_t;
    logic           r_out_hit;
    logic           r_out_last;

    logic [TW-1:0]  sat_cnt;
    logic [63:0]    k64;
    logic [63:0]    p64;
    logic [63:0]    min64;
    logic [63:0]    max64;
    logic [PB:0]    rem_sh;
    logic [PB:0]    rem_sub;
    logic           ge;
    logic [PB-1:0]  rem_nx;
    logic [63:0]    mod_adj;
    logic           par_fix;
    logic           hit;
    logic [PB:0]    ksum;
    logic           out_free;

    // term count clipped to the term limit
    assign sat_cnt = (int'(i_cfg.chain_length) > MAX_TERMS) ? TW'(MAX_TERMS)
                                                             : TW'(i_cfg.chain_length);

    // lift to min_k: one remainder bit a cycle
    always_comb begin
        k64     = 64'(r_k);
        p64     = 64'(r_p);
        min64   = {1'b0, i_cfg.min_k};
        max64   = {1'b0, i_cfg.max_k};
        rem_sh  = {r_rem, r_num[KW-1]};
        rem_sub = rem_sh - {1'b0, r_p};
        ge      = (rem_sh >= {1'b0, r_p});
        rem_nx  = ge ? rem_sub[PB-1:0] : rem_sh[PB-1:0];
        mod_adj = (rem_nx == '0) ? min64 : (min64 + p64 - 64'(rem_nx));
        par_fix = i_cfg.half_k && (i_cfg.base_two ? !r_adj[0] : r_adj[0]);
        hit     = r_ok && (r_adj <= max64);
        ksum    = {1'b0, r_k} + (r_k[0] ? {1'b0, r_p} : '0);
        out_free = !r_out_valid || !i_stall;
    end

    // term sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != B_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_p   <= i_p;
                        r_k   <= i_k;
                        r_ok  <= i_k_ok;
                        r_t   <= TW'(1);
                        r_cnt <= sat_cnt;
                        if (sat_cnt != '0) begin
                            r_state <= B_TERM;
                        end
                    end
                end
                B_TERM: begin
                    if (!r_ok) begin
                        r_adj   <= '0;
                        r_state <= B_EMIT;
                    end else if (k64 < min64) begin
                        if (p64 >= min64) begin
                            r_adj   <= k64 + p64;
                            r_state <= B_PAR;
                        end else begin
                            r_num   <= i_cfg.min_k - KW'(r_k);
                            r_rem   <= '0;
                            r_mc    <= MCW'(KW);
                            r_state <= B_MOD;
                        end
                    end else begin
                        r_adj   <= k64;
                        r_state <= B_PAR;
                    end
                end
                B_MOD: begin
                    r_rem <= rem_nx;
                    r_num <= r_num << 1;
                    r_mc  <= r_mc - MCW'(1);
                    if (r_mc == MCW'(1)) begin
                        r_adj   <= mod_adj;
                        r_state <= B_PAR;
                    end
                end
                B_PAR: begin
                    if (par_fix) begin
                        r_adj <= r_adj + p64;
                    end
                    r_state <= B_EMIT;
                end
                B_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_p     <= r_p;
                        r_out_k     <= hit ? r_adj[KW-1:0] : '0;
                        r_out_t     <= CLEN_W'(r_t);
                        r_out_hit   <= hit;
                        r_out_last  <= (r_t == r_cnt);
                        r_k         <= ksum[PB:1];
                        r_t         <= r_t + TW'(1);
                        r_state     <= (r_t == r_cnt) ? B_IDLE : B_TERM;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_pop        = (r_state == B_IDLE) && !i_empty;
    assign o_valid      = r_out_valid;
    assign o_prime_out  = r_out_p;
    assign o_k_value    = r_out_k;
    assign o_term_index = r_out_t;
    assign o_hit        = r_out_hit;
    assign o_last       = r_out_last;

endmodule

### rtl/cunningham_chain_sieve_step.sv
// channel  | direction | handshake           | payload
// input    | in        | i_valid / o_stall   | i_prime
// result   | out       | o_valid / i_stall   | o_prime_out o_k_value o_term_index o_hit o_last
// config   | in        | i_cfg_we            | i_cfg_index i_cfg_data
//
// front: base mod p, then a restoring division per Euclid step, then per exponent
//   bit one or two shift-add modular multiplies
// back: per term; k below min_k is lifted by a remainder step when p is also below min_k
// a two-beat queue lets the front start the next prime while the back emits terms
// reset is synchronous, active low; one stalled result beat is held in the output register
module cunningham_chain_sieve_step #(
    parameter int MAX_TERMS  = ccs_pkg::MAX_TERMS_DEF,
    parameter int PRIME_BITS = ccs_pkg::PRIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ccs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ccs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [PRIME_BITS-1:0]            i_prime,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [PRIME_BITS-1:0]            o_prime_out,
    output logic [ccs_pkg::KW-1:0]           o_k_value,
    output logic [ccs_pkg::CLEN_W-1:0]       o_term_index,
    output logic                             o_hit,
    output logic                             o_last
);
    import ccs_pkg::*;

    localparam int PB = PRIME_BITS;
    localparam int QW = 2 * PB + 1;

    logic [BASE_W-1:0] r_base;
    logic [EXP_W-1:0]  r_exponent;
    logic [CLEN_W-1:0] r_chain;
    logic              r_second;
    logic              r_half_k;
    logic [KW-1:0]     r_min_k;
    logic [KW-1:0]     r_max_k;

    t_front_cfg    front_cfg;
    t_back_cfg     back_cfg;
    logic          push;
    logic          full;
    logic          pop;
    logic          empty;
    logic [PB-1:0] f_p;
    logic [PB-1:0] f_k;
    logic          f_ok;
    logic [QW-1:0] q_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= RST_BASE;
            r_exponent <= RST_EXPONENT;
            r_chain    <= RST_CHAIN;
            r_second   <= 1'b0;
            r_half_k   <= 1'b0;
            r_min_k    <= RST_MIN_K;
            r_max_k    <= RST_MAX_K;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE:     r_base     <= i_cfg_data[BASE_W-1:0];
                CFG_EXPONENT: r_exponent <= i_cfg_data[EXP_W-1:0];
                CFG_CHAIN:    r_chain    <= i_cfg_data[CLEN_W-1:0];
                CFG_SECOND:   r_second   <= i_cfg_data[0];
                CFG_HALF_K:   r_half_k   <= i_cfg_data[0];
                CFG_MIN_K:    r_min_k    <= i_cfg_data[KW-1:0];
                CFG_MAX_K:    r_max_k    <= i_cfg_data[KW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        front_cfg.base         = r_base;
        front_cfg.exponent     = r_exponent;
        front_cfg.second_kind  = r_second;
        back_cfg.base_two      = (r_base == BASE_W'(2));
        back_cfg.half_k        = r_half_k;
        back_cfg.chain_length  = r_chain;
        back_cfg.min_k         = r_min_k;
        back_cfg.max_k         = r_max_k;
    end

    // starting k per prime
    ccs_front #(.PRIME_BITS(PB)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (front_cfg),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_prime (i_prime),
        .o_push  (push),
        .i_full  (full),
        .o_p     (f_p),
        .o_k     (f_k),
        .o_k_ok  (f_ok)
    );

    // decoupling queue
    ccs_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_p, f_k, f_ok}),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (empty)
    );

    // per-term results
    ccs_back #(.PRIME_BITS(PB), .MAX_TERMS(MAX_TERMS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (back_cfg),
        .i_empty      (empty),
        .i_p          (q_out[QW-1:PB+1]),
        .i_k          (q_out[PB:1]),
        .i_k_ok       (q_out[0]),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_prime_out  (o_prime_out),
        .o_k_value    (o_k_value),
        .o_term_index (o_term_index),
        .o_hit        (o_hit),
        .o_last       (o_last)
    );

`ifndef NO_ASSERTIONS
    // a miss carries no multiplier
    ap_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_k_value == '0))
        else $error("miss beat with nonzero k");

    // a hit lies inside the sieve range
    ap_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_k_value >= r_min_k && o_k_value <= r_max_k))
        else $error("hit beat outside k range");
`endif

endmodule
